/* rtl/multi_pattern_string_matcher_defines.svh */
// ---------------------------------------------------------------------------
// multi_pattern_string_matcher_defines
// Assertion macros shared by the matcher RTL.
// ---------------------------------------------------------------------------
`ifndef MULTI_PATTERN_STRING_MATCHER_DEFINES_SVH
`define MULTI_PATTERN_STRING_MATCHER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define MPSM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define MPSM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/mpsm_pkg.sv */
// ---------------------------------------------------------------------------
// mpsm_pkg
// Shared types and constants of the multi-pattern string matcher.
// ---------------------------------------------------------------------------
package mpsm_pkg;

    localparam int ALPHABET_SIZE_DEF = 26;
    localparam int MAX_NODES_DEF     = 1024;
    localparam int MAX_PATTERNS_DEF  = 256;
    localparam int MAX_DEPTH_DEF     = 32;
    localparam int RESULT_LIMIT      = 32;
    localparam logic [7:0] BASE_RESET = 8'd97;   // 'a'

    typedef enum logic [1:0] {
        CMD_PAT_SYM = 2'd0,
        CMD_PAT_END = 2'd1,
        CMD_BUILD   = 2'd2,
        CMD_TEXT    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_RANGE   = 2'd1,
        ST_FULL    = 2'd2,
        ST_TOOLONG = 2'd3
    } t_status;

    // field write enables of the node store
    typedef struct packed {
        logic cv;
        logic pat;
        logic links;
        logic depth;
    } t_nwmask;

    typedef struct packed {
        logic        match_valid;
        logic [7:0]  pattern_id;
        logic [31:0] start_position;
        logic        last;
        t_status     status;
    } t_result;

endpackage

/* rtl/mpsm_node_ram.sv */
// ---------------------------------------------------------------------------
// mpsm_node_ram
// Per-node store: child mask, pattern mark and number, links and depth.
// One write port with field enables, one registered read port.
// ---------------------------------------------------------------------------
module mpsm_node_ram
    import mpsm_pkg::*;
#(
    parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF,
    parameter int MAX_NODES     = MAX_NODES_DEF,
    parameter int NODE_W        = 10,
    parameter int PID_W         = 8,
    parameter int DEP_W         = 6
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  t_nwmask                  i_wmask,
    input  logic [NODE_W-1:0]        i_waddr,
    input  logic [ALPHABET_SIZE-1:0] i_wcv,
    input  logic                     i_wends,
    input  logic [PID_W-1:0]         i_wpid,
    input  logic [NODE_W-1:0]        i_wfail,
    input  logic [NODE_W-1:0]        i_wdict,
    input  logic [DEP_W-1:0]         i_wdep,
    input  logic                     i_re,
    input  logic [NODE_W-1:0]        i_raddr,
    output logic [ALPHABET_SIZE-1:0] o_cv,
    output logic                     o_ends,
    output logic [PID_W-1:0]         o_pid,
    output logic [NODE_W-1:0]        o_fail,
    output logic [NODE_W-1:0]        o_dict,
    output logic [DEP_W-1:0]         o_dep
);

    logic [ALPHABET_SIZE-1:0] m_cv   [MAX_NODES];
    logic                     m_ends [MAX_NODES];
    logic [PID_W-1:0]         m_pid  [MAX_NODES];
    logic [NODE_W-1:0]        m_fail [MAX_NODES];
    logic [NODE_W-1:0]        m_dict [MAX_NODES];
    logic [DEP_W-1:0]         m_dep  [MAX_NODES];

    // write, field by field
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            if (i_wmask.cv) m_cv[i_waddr] <= i_wcv;
            if (i_wmask.pat) begin
                m_ends[i_waddr] <= i_wends;
                m_pid[i_waddr]  <= i_wpid;
            end
            if (i_wmask.links) begin
                m_fail[i_waddr] <= i_wfail;
                m_dict[i_waddr] <= i_wdict;
            end
            if (i_wmask.depth) m_dep[i_waddr] <= i_wdep;
        end
    end

    // registered read, held while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_cv   <= m_cv[i_raddr];
            o_ends <= m_ends[i_raddr];
            o_pid  <= m_pid[i_raddr];
            o_fail <= m_fail[i_raddr];
            o_dict <= m_dict[i_raddr];
            o_dep  <= m_dep[i_raddr];
        end
    end

endmodule

/* rtl/mpsm_slot_ram.sv */
// ---------------------------------------------------------------------------
// mpsm_slot_ram
// Per (node, symbol) store: goto entry on port A, trie child on port B.
// Writes go to the port B address.
// ---------------------------------------------------------------------------
module mpsm_slot_ram
    import mpsm_pkg::*;
#(
    parameter int SLOTS  = MAX_NODES_DEF * ALPHABET_SIZE_DEF,
    parameter int ADDR_W = 15,
    parameter int NODE_W = 10
) (
    input  logic              i_clk,
    input  logic              i_we_goto,
    input  logic              i_we_child,
    input  logic [NODE_W-1:0] i_wdata,
    input  logic              i_re_a,
    input  logic [ADDR_W-1:0] i_addr_a,
    input  logic              i_re_b,
    input  logic [ADDR_W-1:0] i_addr_b,
    output logic [NODE_W-1:0] o_goto,
    output logic [NODE_W-1:0] o_child
);

    logic [NODE_W-1:0] m_goto  [SLOTS];
    logic [NODE_W-1:0] m_child [SLOTS];

    // goto table
    always_ff @(posedge i_clk) begin
        if (i_we_goto) m_goto[i_addr_b] <= i_wdata;
        if (i_re_a) o_goto <= m_goto[i_addr_a];
    end

    // trie children
    always_ff @(posedge i_clk) begin
        if (i_we_child) m_child[i_addr_b] <= i_wdata;
        if (i_re_b) o_child <= m_child[i_addr_b];
    end

endmodule

/* rtl/mpsm_out_reg.sv */
// ---------------------------------------------------------------------------
// mpsm_out_reg
// Output register between the sequencer and the result stream.
// ---------------------------------------------------------------------------
module mpsm_out_reg
    import mpsm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_res,
    output logic    o_rdy,
    output logic    o_valid,
    input  logic    i_tready,
    output t_result o_res
);

    logic r_valid;
    t_result r_res;

    assign o_rdy   = !r_valid || i_tready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push && o_rdy) begin
            r_valid <= 1'b1;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_push && o_rdy) r_res <= i_res;
    end

endmodule

/* rtl/multi_pattern_string_matcher.sv */
// ---------------------------------------------------------------------------
// multi_pattern_string_matcher
// Aho-Corasick matcher: trie load, link build and text scan over two memories.
// ---------------------------------------------------------------------------
// Pattern symbol: node and child read, check, hook-up of a new node if the child is missing, then emit.
// End of pattern: mark, then emit. Text symbol: goto read, one node read per dictionary-chain node visited, emit.
// Build: a node scan per level to MAX_DEPTH; per slot of a node on that level a read, a check, a link step for a child.
// A result register parts the output; items are taken one at a time.
// Synchronous active-low reset; the S_INIT state after reset initializes the root node.
module multi_pattern_string_matcher
    import mpsm_pkg::*;
#(
    parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF,
    parameter int MAX_NODES     = MAX_NODES_DEF,
    parameter int MAX_PATTERNS  = MAX_PATTERNS_DEF,
    parameter int MAX_DEPTH     = MAX_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,     // alphabet_base
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // [7:0] symbol
    input  logic [1:0]  s_axis_tuser,    // [1:0] command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,    // [7:0] pattern_id, [39:8] start_position
    output logic        m_axis_tlast,
    output logic [2:0]  m_axis_tuser     // [0] match_valid, [2:1] status
);

    `include "multi_pattern_string_matcher_defines.svh"

    localparam int NODE_W = $clog2(MAX_NODES);
    localparam int CNT_W  = $clog2(MAX_NODES + 1);
    localparam int SYM_W  = $clog2(ALPHABET_SIZE);
    localparam int DEP_W  = $clog2(MAX_DEPTH + 1);
    localparam int PID_W  = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
    localparam int PC_W   = $clog2(MAX_PATTERNS + 1);
    localparam int SLOTS  = MAX_NODES * ALPHABET_SIZE;
    localparam int ADDR_W = $clog2(SLOTS);
    localparam int K_W    = $clog2(RESULT_LIMIT + 1);
    localparam logic [ADDR_W-1:0] A_L = ADDR_W'(ALPHABET_SIZE);

    typedef enum logic [12:0] {
        S_INIT    = 13'b0000000000001,
        S_IDLE    = 13'b0000000000010,
        S_LD_CHK  = 13'b0000000000100,
        S_LD_UPD  = 13'b0000000001000,
        S_EMIT    = 13'b0000000010000,
        S_TX_GO   = 13'b0000000100000,
        S_TX_CHN  = 13'b0000001000000,
        S_BD_SCAN = 13'b0000010000000,
        S_BD_NODE = 13'b0000100000000,
        S_BD_RD   = 13'b0001000000000,
        S_BD_CHK  = 13'b0010000000000,
        S_BD_LNK  = 13'b0100000000000,
        S_BD_DONE = 13'b1000000000000
    } t_state;

    // control registers
    t_state            r_state, n_state;
    logic [7:0]        r_base;
    logic [NODE_W-1:0] r_cur, n_cur;
    logic [NODE_W-1:0] r_load, n_load;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [PC_W-1:0]   r_pcnt, n_pcnt;
    logic [31:0]       r_tp, n_tp;
    logic              r_built, n_built;

    // working registers
    logic [DEP_W-1:0]         r_lvl, n_lvl;
    logic [CNT_W-1:0]         r_n, n_n;
    logic [SYM_W-1:0]         r_c, n_c;
    logic [NODE_W-1:0]        r_u, n_u;
    logic [NODE_W-1:0]        r_fu, n_fu;
    logic [ALPHABET_SIZE-1:0] r_cv, n_cv;
    logic [NODE_W-1:0]        r_f, n_f;
    logic [NODE_W-1:0]        r_w, n_w;
    logic [NODE_W-1:0]        r_new, n_new;
    logic [K_W-1:0]           r_k, n_k;
    logic                     r_pend_v, n_pend_v;
    logic [7:0]               r_pend_pid, n_pend_pid;
    logic [31:0]              r_pend_start, n_pend_start;
    t_result                  r_res, n_res;

    // memory ports
    logic                     w_n_we, w_n_re;
    t_nwmask                  w_n_mask;
    logic [NODE_W-1:0]        w_n_waddr, w_n_raddr;
    logic [ALPHABET_SIZE-1:0] w_n_wcv;
    logic                     w_n_wends;
    logic [PID_W-1:0]         w_n_wpid;
    logic [NODE_W-1:0]        w_n_wfail, w_n_wdict;
    logic [DEP_W-1:0]         w_n_wdep;
    logic [ALPHABET_SIZE-1:0] rd_cv;
    logic                     rd_ends;
    logic [PID_W-1:0]         rd_pid;
    logic [NODE_W-1:0]        rd_fail, rd_dict;
    logic [DEP_W-1:0]         rd_dep;

    logic                     w_s_we_goto, w_s_we_child, w_s_re_a, w_s_re_b;
    logic [NODE_W-1:0]        w_s_wdata, w_node_a, w_node_b;
    logic [SYM_W-1:0]         w_c;
    logic [ADDR_W-1:0]        w_addr_a, w_addr_b;
    logic [NODE_W-1:0]        rd_goto, rd_child;

    logic                     w_push, w_out_rdy, w_out_valid;
    t_result                  w_pres, w_out_res;

    // input decode
    logic [7:0] w_pos8;
    logic       w_pos_ok;
    t_cmd       w_cmd;
    logic       w_acc;
    logic [NODE_W-1:0] w_g;
    logic [K_W-1:0]    w_kn;
    logic [31:0]       w_start;

    assign w_pos8   = s_axis_tdata - r_base;
    assign w_pos_ok = w_pos8 < 8'(ALPHABET_SIZE);
    assign w_cmd    = t_cmd'(s_axis_tuser);
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_acc    = s_axis_tvalid && s_axis_tready;

    // slot addresses: node * alphabet + symbol
    assign w_c      = (r_state == S_IDLE) ? w_pos8[SYM_W-1:0] : r_c;
    assign w_addr_a = ADDR_W'(w_node_a) * A_L + ADDR_W'(w_c);
    assign w_addr_b = ADDR_W'(w_node_b) * A_L + ADDR_W'(w_c);

    // root row of the goto table points to the root for missing children
    assign w_g     = (r_u == '0) ? '0 : rd_goto;
    assign w_kn    = r_k + K_W'(rd_ends);
    assign w_start = r_tp - 32'(rd_dep) + 32'd1;

    // sequencer
    always_comb begin
        n_state = r_state;  n_cur = r_cur;  n_load = r_load;  n_cnt = r_cnt;
        n_pcnt = r_pcnt;    n_tp = r_tp;    n_built = r_built;
        n_lvl = r_lvl;  n_n = r_n;  n_c = r_c;  n_u = r_u;  n_fu = r_fu;
        n_cv = r_cv;  n_f = r_f;  n_w = r_w;  n_new = r_new;  n_k = r_k;
        n_pend_v = r_pend_v;  n_pend_pid = r_pend_pid;  n_pend_start = r_pend_start;
        n_res = r_res;

        w_n_we = 1'b0;  w_n_re = 1'b0;  w_n_mask = '0;
        w_n_waddr = r_load;  w_n_raddr = r_load;
        w_n_wcv = '0;  w_n_wends = 1'b0;  w_n_wpid = '0;
        w_n_wfail = '0;  w_n_wdict = '0;  w_n_wdep = '0;
        w_s_we_goto = 1'b0;  w_s_we_child = 1'b0;  w_s_re_a = 1'b0;  w_s_re_b = 1'b0;
        w_s_wdata = r_w;  w_node_a = r_cur;  w_node_b = r_load;
        w_push = 1'b0;  w_pres = r_res;

        unique case (r_state)
            S_INIT: begin
                // root: no children, no mark, null links, depth zero
                w_n_we = 1'b1;
                w_n_mask = '{cv: 1'b1, pat: 1'b1, links: 1'b1, depth: 1'b1};
                w_n_waddr = '0;
                n_state = S_IDLE;
            end
            S_IDLE: begin
                n_res = '{match_valid: 1'b0, pattern_id: 8'd0, start_position: 32'd0,
                          last: 1'b1, status: ST_OK};
                if (w_acc) begin
                    unique case (w_cmd)
                        CMD_PAT_SYM: begin
                            n_c = w_pos8[SYM_W-1:0];
                            if (!w_pos_ok) begin
                                n_res.status = ST_RANGE;
                                n_state = S_EMIT;
                            end else begin
                                w_n_re = 1'b1;
                                w_s_re_b = 1'b1;
                                n_state = S_LD_CHK;
                            end
                        end
                        CMD_PAT_END: begin
                            if (r_pcnt >= PC_W'(MAX_PATTERNS)) begin
                                n_res.status = ST_FULL;
                            end else begin
                                w_n_we = 1'b1;
                                w_n_mask.pat = 1'b1;
                                w_n_wends = 1'b1;
                                w_n_wpid = PID_W'(r_pcnt);
                                n_pcnt = r_pcnt + 1'b1;
                            end
                            n_load = '0;
                            n_state = S_EMIT;
                        end
                        CMD_BUILD: begin
                            n_lvl = '0;
                            n_n = '0;
                            n_state = S_BD_SCAN;
                        end
                        default: begin
                            if (!w_pos_ok) begin
                                n_res.status = ST_RANGE;
                                n_state = S_EMIT;
                            end else if (!r_built) begin
                                n_tp = r_tp + 32'd1;
                                n_state = S_EMIT;
                            end else begin
                                w_s_re_a = 1'b1;
                                n_state = S_TX_GO;
                            end
                        end
                    endcase
                end
            end
            S_LD_CHK: begin
                if (rd_cv[r_c]) begin
                    n_load = rd_child;
                    n_state = S_EMIT;
                end else if (rd_dep >= DEP_W'(MAX_DEPTH)) begin
                    n_res.status = ST_TOOLONG;
                    n_state = S_EMIT;
                end else if (r_cnt >= CNT_W'(MAX_NODES)) begin
                    n_res.status = ST_FULL;
                    n_state = S_EMIT;
                end else begin
                    // create the new node in full
                    w_n_we = 1'b1;
                    w_n_mask = '{cv: 1'b1, pat: 1'b1, links: 1'b1, depth: 1'b1};
                    w_n_waddr = r_cnt[NODE_W-1:0];
                    w_n_wdep = rd_dep + 1'b1;
                    n_new = r_cnt[NODE_W-1:0];
                    n_cv = rd_cv | (ALPHABET_SIZE'(1) << r_c);
                    n_state = S_LD_UPD;
                end
            end
            S_LD_UPD: begin
                // hook the new node under its parent
                w_n_we = 1'b1;
                w_n_mask.cv = 1'b1;
                w_n_wcv = r_cv;
                w_s_we_child = 1'b1;
                w_s_wdata = r_new;
                n_load = r_new;
                n_cnt = r_cnt + 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                w_push = 1'b1;
                if (w_out_rdy) n_state = S_IDLE;
            end
            S_TX_GO: begin
                n_cur = rd_goto;
                n_k = '0;
                n_pend_v = 1'b0;
                if (rd_goto == '0) begin
                    n_tp = r_tp + 32'd1;
                    n_state = S_EMIT;
                end else begin
                    w_n_re = 1'b1;
                    w_n_raddr = rd_goto;
                    n_state = S_TX_CHN;
                end
            end
            S_TX_CHN: begin
                // one chain node per cycle, stalled when a match meets a full output; a match retires the one held
                if (!(rd_ends && r_pend_v && !w_out_rdy)) begin
                    if (rd_ends) begin
                        w_push = r_pend_v;
                        w_pres = '{match_valid: 1'b1, pattern_id: r_pend_pid,
                                   start_position: r_pend_start, last: 1'b0, status: ST_OK};
                        n_pend_v = 1'b1;
                        n_pend_pid = 8'(rd_pid);
                        n_pend_start = w_start;
                        n_k = w_kn;
                    end
                    if ((rd_ends && w_kn == K_W'(RESULT_LIMIT)) || rd_dict == '0) begin
                        if (rd_ends) begin
                            n_res = '{match_valid: 1'b1, pattern_id: 8'(rd_pid),
                                      start_position: w_start, last: 1'b1, status: ST_OK};
                        end else if (r_pend_v) begin
                            n_res = '{match_valid: 1'b1, pattern_id: r_pend_pid,
                                      start_position: r_pend_start, last: 1'b1,
                                      status: ST_OK};
                        end
                        n_tp = r_tp + 32'd1;
                        n_state = S_EMIT;
                    end else begin
                        w_n_re = 1'b1;
                        w_n_raddr = rd_dict;
                    end
                end
            end
            S_BD_SCAN: begin
                // level-order walk: every node of depth r_lvl, then the next level
                if (r_n == r_cnt) begin
                    n_n = '0;
                    if (r_lvl == DEP_W'(MAX_DEPTH)) begin
                        n_state = S_BD_DONE;
                    end else begin
                        n_lvl = r_lvl + 1'b1;
                    end
                end else begin
                    w_n_re = 1'b1;
                    w_n_raddr = r_n[NODE_W-1:0];
                    n_state = S_BD_NODE;
                end
            end
            S_BD_NODE: begin
                if (rd_dep == r_lvl) begin
                    n_u = r_n[NODE_W-1:0];
                    n_fu = rd_fail;
                    n_cv = rd_cv;
                    n_c = '0;
                    n_state = S_BD_RD;
                end else begin
                    n_n = r_n + 1'b1;
                    n_state = S_BD_SCAN;
                end
            end
            S_BD_RD: begin
                w_node_a = r_fu;
                w_node_b = r_u;
                w_s_re_a = 1'b1;
                w_s_re_b = 1'b1;
                n_state = S_BD_CHK;
            end
            S_BD_CHK: begin
                w_node_b = r_u;
                if (r_cv[r_c]) begin
                    n_f = w_g;
                    n_w = rd_child;
                    w_n_re = 1'b1;
                    w_n_raddr = w_g;
                    n_state = S_BD_LNK;
                end else begin
                    w_s_we_goto = 1'b1;
                    w_s_wdata = w_g;
                    if (r_c == SYM_W'(ALPHABET_SIZE - 1)) begin
                        n_n = r_n + 1'b1;
                        n_state = S_BD_SCAN;
                    end else begin
                        n_c = r_c + 1'b1;
                        n_state = S_BD_RD;
                    end
                end
            end
            S_BD_LNK: begin
                // child link: failure target and nearest marked suffix
                w_n_we = 1'b1;
                w_n_mask.links = 1'b1;
                w_n_waddr = r_w;
                w_n_wfail = r_f;
                w_n_wdict = (r_f == '0) ? '0 : (rd_ends ? r_f : rd_dict);
                w_node_b = r_u;
                w_s_we_goto = 1'b1;
                w_s_wdata = r_w;
                if (r_c == SYM_W'(ALPHABET_SIZE - 1)) begin
                    n_n = r_n + 1'b1;
                    n_state = S_BD_SCAN;
                end else begin
                    n_c = r_c + 1'b1;
                    n_state = S_BD_RD;
                end
            end
            S_BD_DONE: begin
                n_cur = '0;
                n_tp = '0;
                n_built = 1'b1;
                n_state = S_EMIT;
            end
            default: n_state = S_INIT;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_base  <= BASE_RESET;
            r_cur   <= '0;
            r_load  <= '0;
            r_cnt   <= CNT_W'(1);
            r_pcnt  <= '0;
            r_tp    <= '0;
            r_built <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_base <= i_cfg_wdata;
            r_cur   <= n_cur;
            r_load  <= n_load;
            r_cnt   <= n_cnt;
            r_pcnt  <= n_pcnt;
            r_tp    <= n_tp;
            r_built <= n_built;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_lvl <= n_lvl;  r_n <= n_n;  r_c <= n_c;  r_u <= n_u;  r_fu <= n_fu;
        r_cv <= n_cv;  r_f <= n_f;  r_w <= n_w;  r_new <= n_new;  r_k <= n_k;
        r_pend_v <= n_pend_v;  r_pend_pid <= n_pend_pid;  r_pend_start <= n_pend_start;
        r_res <= n_res;
    end

    // in S_EMIT the held result goes out
    t_result w_push_res;
    assign w_push_res = (r_state == S_EMIT) ? r_res : w_pres;

    mpsm_node_ram #(
        .ALPHABET_SIZE (ALPHABET_SIZE),
        .MAX_NODES     (MAX_NODES),
        .NODE_W        (NODE_W),
        .PID_W         (PID_W),
        .DEP_W         (DEP_W)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (w_n_we),
        .i_wmask (w_n_mask),
        .i_waddr (w_n_waddr),
        .i_wcv   (w_n_wcv),
        .i_wends (w_n_wends),
        .i_wpid  (w_n_wpid),
        .i_wfail (w_n_wfail),
        .i_wdict (w_n_wdict),
        .i_wdep  (w_n_wdep),
        .i_re    (w_n_re),
        .i_raddr (w_n_raddr),
        .o_cv    (rd_cv),
        .o_ends  (rd_ends),
        .o_pid   (rd_pid),
        .o_fail  (rd_fail),
        .o_dict  (rd_dict),
        .o_dep   (rd_dep)
    );

    mpsm_slot_ram #(
        .SLOTS  (SLOTS),
        .ADDR_W (ADDR_W),
        .NODE_W (NODE_W)
    ) u_slot_ram (
        .i_clk      (i_clk),
        .i_we_goto  (w_s_we_goto),
        .i_we_child (w_s_we_child),
        .i_wdata    (w_s_wdata),
        .i_re_a     (w_s_re_a),
        .i_addr_a   (w_addr_a),
        .i_re_b     (w_s_re_b),
        .i_addr_b   (w_addr_b),
        .o_goto     (rd_goto),
        .o_child    (rd_child)
    );

    mpsm_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_res    (w_push_res),
        .o_rdy    (w_out_rdy),
        .o_valid  (w_out_valid),
        .i_tready (m_axis_tready),
        .o_res    (w_out_res)
    );

    assign m_axis_tvalid = w_out_valid;
    assign m_axis_tdata  = {w_out_res.start_position, w_out_res.pattern_id};
    assign m_axis_tlast  = w_out_res.last;
    assign m_axis_tuser  = {w_out_res.status, w_out_res.match_valid};

    // checks
    `MPSM_ASSERT_IMP(a_push_room, w_push && r_state == S_TX_CHN, w_out_rdy, "word pushed into full output register")
    `MPSM_ASSERT_NXT(a_busy_after_accept, w_acc, !s_axis_tready, "input taken while item still in work")
    `MPSM_ASSERT_IMP(a_node_count, 1'b1, r_cnt <= CNT_W'(MAX_NODES) && r_cnt != '0, "node count out of range")
    `MPSM_ASSERT_IMP(a_chain_limit, r_state == S_TX_CHN, r_k < K_W'(RESULT_LIMIT), "match count passed result limit")

endmodule

/* bench/multi_pattern_string_matcher_tb.sv */
// ---------------------------------------------------------------------------
// multi_pattern_string_matcher_tb
// Self-checking bench for the Aho-Corasick matcher. A scoreboard class keeps
// its own trie, failure and dictionary links and goto table. It predicts every
// result word from the accepted input words and checks the output stream in
// order. The run covers directed patterns, random load/build/scan sessions
// under several alphabet bases, and the node and pattern tables filled up.
// ---------------------------------------------------------------------------
module multi_pattern_string_matcher_tb;
    import mpsm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSYM      = ALPHABET_SIZE_DEF;
    localparam int NODES     = MAX_NODES_DEF;
    localparam int PATTERNS  = MAX_PATTERNS_DEF;
    localparam int DEPTH_MAX = MAX_DEPTH_DEF;
    localparam int QUIET_LIMIT = 600000;   // longer than the longest build with a full node table
    localparam int SETTLE_CYCLES = 20;

    // trie model plus queue of the result words still owed by the block
    class match_scoreboard;
        bit [NSYM-1:0] kid_valid [NODES];
        bit [9:0]      kid       [NODES*NSYM];
        bit [9:0]      next_node [NODES*NSYM];
        bit [9:0]      fail_node [NODES];
        bit [9:0]      dict_node [NODES];
        bit            ends_here [NODES];
        bit [7:0]      pat_num   [NODES];
        bit [5:0]      node_dep  [NODES];
        int            bfs_order [NODES];
        int            cur_node;
        int            load_node;
        int            node_cnt;
        int            pat_cnt;
        bit [31:0]     text_pos;
        bit [7:0]      base;
        t_result       expected_results [$];
        int            errors;

        function void clear_node(int n, int d);
            kid_valid[n] = '0;
            ends_here[n] = 1'b0;
            pat_num[n]   = '0;
            fail_node[n] = '0;
            dict_node[n] = '0;
            node_dep[n]  = d;
            for (int c = 0; c < NSYM; c++) begin
                kid[n*NSYM+c]       = '0;
                next_node[n*NSYM+c] = '0;
            end
        endfunction

        function void build_links();
            int head;
            int tail;
            int u;
            int fu;
            int w;
            int f;
            int slot;
            head = 0;
            tail = 0;
            fail_node[0] = '0;
            dict_node[0] = '0;
            for (int c = 0; c < NSYM; c++) begin
                if (kid_valid[0][c]) begin
                    w = kid[c];
                    next_node[c] = w;
                    fail_node[w] = '0;
                    dict_node[w] = '0;
                    bfs_order[tail++] = w;
                end else begin
                    next_node[c] = '0;
                end
            end
            // breadth first: a node's failure target is finished before its children
            while (head < tail) begin
                u = bfs_order[head++];
                fu = fail_node[u];
                for (int c = 0; c < NSYM; c++) begin
                    slot = u*NSYM + c;
                    if (kid_valid[u][c]) begin
                        w = kid[slot];
                        f = next_node[fu*NSYM+c];
                        fail_node[w] = f;
                        if (f == 0)
                            dict_node[w] = '0;
                        else if (ends_here[f])
                            dict_node[w] = f;
                        else
                            dict_node[w] = dict_node[f];
                        next_node[slot] = w;
                        if (tail < NODES) bfs_order[tail++] = w;
                    end else begin
                        next_node[slot] = next_node[fu*NSYM+c];
                    end
                end
            end
            cur_node = 0;
            text_pos = '0;
        endfunction

        function void reset_state();
            base = BASE_RESET;
            clear_node(0, 0);
            node_cnt  = 1;
            pat_cnt   = 0;
            load_node = 0;
            errors    = 0;
            build_links();
        endfunction

        function void owe(bit mv, bit [7:0] id, bit [31:0] start, bit lst, t_status st);
            t_result r;
            r.match_valid    = mv;
            r.pattern_id     = id;
            r.start_position = start;
            r.last           = lst;
            r.status         = st;
            expected_results.push_back(r);
        endfunction

        // advance the model by one accepted input word
        function void note_word(t_cmd cmd, bit [7:0] sym);
            bit [7:0] idx;
            t_status  st;
            int       v;
            int       k;
            int       n;
            idx = sym - base;
            st  = ST_OK;
            case (cmd)
                CMD_PAT_SYM: begin
                    if (idx >= NSYM) begin
                        st = ST_RANGE;
                    end else if (kid_valid[load_node][idx]) begin
                        load_node = kid[load_node*NSYM+idx];
                    end else if (node_dep[load_node] >= DEPTH_MAX) begin
                        st = ST_TOOLONG;
                    end else if (node_cnt >= NODES) begin
                        st = ST_FULL;
                    end else begin
                        n = node_cnt++;
                        clear_node(n, node_dep[load_node] + 1);
                        kid[load_node*NSYM+idx] = n;
                        kid_valid[load_node][idx] = 1'b1;
                        load_node = n;
                    end
                    owe(0, 0, 0, 1, st);
                end
                CMD_PAT_END: begin
                    if (pat_cnt >= PATTERNS) begin
                        st = ST_FULL;
                    end else begin
                        ends_here[load_node] = 1'b1;
                        pat_num[load_node]   = pat_cnt;
                        pat_cnt++;
                    end
                    load_node = 0;
                    owe(0, 0, 0, 1, st);
                end
                CMD_BUILD: begin
                    build_links();
                    owe(0, 0, 0, 1, ST_OK);
                end
                default: begin
                    if (idx >= NSYM) begin
                        owe(0, 0, 0, 1, ST_RANGE);
                    end else begin
                        cur_node = next_node[cur_node*NSYM+idx];
                        v = cur_node;
                        k = 0;
                        // dictionary chain, longest match first
                        while (v != 0 && k < RESULT_LIMIT) begin
                            if (ends_here[v]) begin
                                owe(1, pat_num[v], text_pos - node_dep[v] + 1, 0, ST_OK);
                                k++;
                            end
                            v = dict_node[v];
                        end
                        text_pos++;
                        if (k == 0)
                            owe(0, 0, 0, 1, ST_OK);
                        else
                            expected_results[expected_results.size()-1].last = 1'b1;
                    end
                end
            endcase
        endfunction

        function void report_mismatch(string what, longint got, longint want);
            errors++;
            if (errors <= 60)
                $display("mismatch %s: got 0x%0h, want 0x%0h at %0t", what, got, want, $realtime);
        endfunction

        function void check_word(t_result got);
            t_result want;
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected word", got, 0);
                return;
            end
            want = expected_results.pop_front();
            if (got.match_valid != want.match_valid)
                report_mismatch("match_valid", got.match_valid, want.match_valid);
            if (got.pattern_id != want.pattern_id)
                report_mismatch("pattern_id", got.pattern_id, want.pattern_id);
            if (got.start_position != want.start_position)
                report_mismatch("start_position", got.start_position, want.start_position);
            if (got.last != want.last)
                report_mismatch("last", got.last, want.last);
            if (got.status != want.status)
                report_mismatch("status", got.status, want.status);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [7:0]  i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;    // [7:0] symbol
    logic [1:0]  s_axis_tuser;    // [1:0] command
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;    // [7:0] pattern_id, [39:8] start_position
    logic        m_axis_tlast;
    logic [2:0]  m_axis_tuser;    // [0] match_valid, [2:1] status

    match_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    int quiet_cycles;

    multi_pattern_string_matcher u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #4 i_clk = ~i_clk;

    // receiver stalls
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // result monitor
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.match_valid    = m_axis_tuser[0];
            got.status         = t_status'(m_axis_tuser[2:1]);
            got.pattern_id     = m_axis_tdata[7:0];
            got.start_position = m_axis_tdata[39:8];
            got.last           = m_axis_tlast;
            sb.check_word(got);
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // one input word; entered and left at a falling edge, valid left high
    task automatic send_word(t_cmd cmd, bit [7:0] sym);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= sym;
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_word(cmd, sym);
        @(negedge i_clk);
    endtask

    // sender pauses until every owed word is back
    task automatic drain(int extra);
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (sb.expected_results.size() != 0) @(negedge i_clk);
        repeat (extra) @(negedge i_clk);
    endtask

    task automatic write_base(bit [7:0] value);
        drain(SETTLE_CYCLES);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.base = value;
    endtask

    task automatic send_string(t_cmd cmd, string s);
        for (int i = 0; i < s.len(); i++) send_word(cmd, s[i]);
    endtask

    task automatic load_string(string s);
        send_string(CMD_PAT_SYM, s);
        send_word(CMD_PAT_END, $urandom);
    endtask

    function automatic bit [7:0] letter(int idx);
        return sb.base + idx;
    endfunction

    function automatic bit [7:0] stray_symbol();
        return sb.base + NSYM + $urandom_range(255 - NSYM);
    endfunction

    // random session: patterns over a few letters, build, then a scan
    task automatic random_session();
        int npat;
        int len;
        int ntext;
        npat = $urandom_range(3, 8);
        for (int p = 0; p < npat; p++) begin
            len = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 4);
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(19) == 0)
                    send_word(CMD_PAT_SYM, stray_symbol());
                send_word(CMD_PAT_SYM, letter($urandom_range(2)));
            end
            send_word(CMD_PAT_END, $urandom);
        end
        send_word(CMD_BUILD, $urandom);
        ntext = $urandom_range(30, 50);
        for (int i = 0; i < ntext; i++) begin
            case ($urandom_range(19))
                0:       send_word(CMD_TEXT, stray_symbol());
                1:       send_word(CMD_TEXT, $urandom);
                2:       send_word(CMD_PAT_SYM, letter($urandom_range(NSYM-1)));
                default: send_word(CMD_TEXT, letter($urandom_range(3)));
            endcase
        end
        // close any half-loaded pattern left by noise
        send_word(CMD_PAT_END, $urandom);
    endtask

    initial begin
        bit [7:0] bases [4];
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_PAT_SYM;
        m_axis_tready = 1'b1;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        quiet_cycles   = 0;
        sb = new;
        sb.reset_state();
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: classic pattern set, repeat, empty pattern, range errors
        load_string("he");
        load_string("she");
        load_string("his");
        load_string("hers");
        load_string("he");
        send_word(CMD_PAT_END, 8'hFF);
        send_word(CMD_PAT_SYM, 8'h00);
        send_word(CMD_PAT_SYM, 8'hFF);
        send_word(CMD_PAT_END, 8'h00);
        send_word(CMD_BUILD, 8'hA5);
        send_string(CMD_TEXT, "ushers");
        send_word(CMD_TEXT, 8'h00);
        send_word(CMD_TEXT, 8'hFF);
        send_string(CMD_TEXT, "z");
        // loaded after the build: not visible until the next one
        load_string("us");
        send_string(CMD_TEXT, "us");
        send_word(CMD_BUILD, 8'h5A);
        send_string(CMD_TEXT, "us");

        // random phases under several alphabet bases
        bases[0] = 8'd0;
        bases[1] = 8'd255;
        bases[2] = $urandom;
        bases[3] = BASE_RESET;
        for (int ph = 0; ph < 4; ph++) begin
            write_base(bases[ph]);
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            random_session();
            random_session();
        end

        // fill the node table with long patterns; they also run past max depth
        send_idle_pct = 10;
        recv_stall_pct = 10;
        while (sb.node_cnt < NODES) begin
            for (int i = 0; i < DEPTH_MAX + 2; i++)
                send_word(CMD_PAT_SYM, letter($urandom_range(NSYM-1)));
            send_word(CMD_PAT_END, $urandom);
        end
        for (int i = 0; i < DEPTH_MAX + 2; i++)
            send_word(CMD_PAT_SYM, letter($urandom_range(NSYM-1)));
        send_word(CMD_PAT_END, $urandom);
        // then the pattern table, with empty patterns
        while (sb.pat_cnt < PATTERNS) send_word(CMD_PAT_END, $urandom);
        send_word(CMD_PAT_END, $urandom);
        send_word(CMD_PAT_END, $urandom);
        send_word(CMD_BUILD, $urandom);
        for (int i = 0; i < 40; i++) send_word(CMD_TEXT, letter($urandom_range(NSYM-1)));

        drain(SETTLE_CYCLES);
        if (sb.expected_results.size() != 0)
            sb.report_mismatch("words left over", sb.expected_results.size(), 0);
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
